// ===== rtl/quadrature_detent_decoder_core_macros.svh =====
// Assertion macros for the quadrature detent decoder checker.
// Each one wraps a clocked concurrent assertion with an active-low reset.
`ifndef QUADRATURE_DETENT_DECODER_CORE_MACROS_SVH
`define QUADRATURE_DETENT_DECODER_CORE_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define QDD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("qdd assertion failed");

// Expression must never be true at a clock edge out of reset.
`define QDD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("qdd forbidden condition seen");

`endif

// ===== rtl/qdd_pkg.sv =====
// Shared types and constants for the quadrature detent decoder.
// No dependencies.
`timescale 1ns / 1ps

package qdd_pkg;

  typedef enum logic [0:0] {
    OpSample = 1'b0,
    OpRead   = 1'b1
  } qdd_op_e;

  typedef enum logic [1:0] {
    CfgReverseDirection = 2'd0,
    CfgEdgesPerDetent   = 2'd1,
    CfgMinEdgeGapUs     = 2'd2,
    CfgPauseResetUs     = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DetentW  = 7;
  localparam int unsigned AccW     = 8;
  localparam int unsigned PendW    = 16;

  localparam logic [DetentW-1:0] MinDetent = DetentW'(2);

  // Direction per (last_phase, phase) transition; both bits changing decodes as 0.
  localparam logic signed [1:0] TransDir [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef struct packed {
    qdd_op_e          operation;
    logic             phase_a;
    logic             phase_b;
    logic [TimeW-1:0] time_us;
  } in_req_t;

  typedef struct packed {
    logic signed [1:0]       step_taken;
    logic signed [PendW-1:0] pending_steps;
  } out_rsp_t;

  typedef struct packed {
    logic               reverse_direction;
    logic [DetentW-1:0] edges_per_detent;
    logic [TimeW-1:0]   min_edge_gap_us;
    logic [TimeW-1:0]   pause_reset_us;
  } cfg_t;

  typedef struct packed {
    logic                   primed;
    logic [1:0]             last_phase;
    logic [TimeW-1:0]       last_edge_time;
    logic signed [AccW-1:0] edge_acc;
  } dec_state_t;

endpackage

// ===== rtl/qdd_step.sv =====
// Next-state and result logic for one request of the detent decoder.
// Purely combinational; depends on qdd_pkg.
`timescale 1ns / 1ps

module qdd_step import qdd_pkg::*; #(
  parameter int unsigned STEP_COUNT_BITS = 16
) (
  input  cfg_t                              cfg_i,
  input  in_req_t                           req_i,
  input  dec_state_t                        state_i,
  input  logic signed [STEP_COUNT_BITS-1:0] count_i,
  output dec_state_t                        state_o,
  output logic signed [STEP_COUNT_BITS-1:0] count_o,
  output out_rsp_t                          rsp_o
);

  localparam logic signed [STEP_COUNT_BITS-1:0] CntMax =
    {1'b0, {(STEP_COUNT_BITS-1){1'b1}}};
  localparam logic signed [STEP_COUNT_BITS-1:0] CntMin =
    {1'b1, {(STEP_COUNT_BITS-1){1'b0}}};

  logic [1:0]                        phase;
  logic [TimeW-1:0]                  gap;
  logic signed [1:0]                 dir_raw;
  logic signed [1:0]                 dir;
  logic [DetentW-1:0]                detent;
  logic signed [AccW:0]              acc_base;
  logic signed [AccW:0]              acc_sum;
  logic signed [AccW:0]              det_pos;
  logic signed [1:0]                 taken;
  logic signed [31:0]                count_wide;

  assign phase   = {req_i.phase_a, req_i.phase_b};
  assign gap     = req_i.time_us - state_i.last_edge_time;
  assign dir_raw = TransDir[{state_i.last_phase, phase}];
  assign dir     = cfg_i.reverse_direction ? -dir_raw : dir_raw;
  assign detent  = (cfg_i.edges_per_detent < MinDetent) ? MinDetent
                                                         : cfg_i.edges_per_detent;
  assign det_pos = signed'({2'b00, detent});

  // long pause drops the partial detent before this edge is added
  assign acc_base = (gap > cfg_i.pause_reset_us) ? '0
                                                 : (AccW+1)'(state_i.edge_acc);
  assign acc_sum  = acc_base + (AccW+1)'(dir);

  always_comb begin
    state_o = state_i;
    count_o = count_i;
    taken   = 2'sd0;
    unique case (req_i.operation)
      OpSample: begin
        if (!state_i.primed) begin
          state_o.primed         = 1'b1;
          state_o.last_phase     = phase;
          state_o.last_edge_time = req_i.time_us;
        end else if (phase != state_i.last_phase) begin
          state_o.last_phase = phase;
          if (gap >= cfg_i.min_edge_gap_us) begin
            state_o.last_edge_time = req_i.time_us;
            state_o.edge_acc       = AccW'(acc_base);
            if (dir != 2'sd0) begin
              if (acc_sum >= det_pos) begin
                state_o.edge_acc = '0;
                if (count_i != CntMax) count_o = count_i + 1'b1;
              end else if (acc_sum <= -det_pos) begin
                state_o.edge_acc = '0;
                if (count_i != CntMin) count_o = count_i - 1'b1;
              end else begin
                state_o.edge_acc = AccW'(acc_sum);
              end
            end
          end
        end
      end
      OpRead: begin
        if (count_i > 0) begin
          count_o = count_i - 1'b1;
          taken   = 2'sd1;
        end else if (count_i < 0) begin
          count_o = count_i + 1'b1;
          taken   = -2'sd1;
        end
      end
      default: ;
    endcase
  end

  assign count_wide          = 32'(count_o);
  assign rsp_o.step_taken    = taken;
  assign rsp_o.pending_steps = count_wide[PendW-1:0];

endmodule

// ===== rtl/quadrature_detent_decoder_core.sv =====
// Quadrature detent decoder, top level: request register, step logic and
// result register, plus the configuration registers. Depends on qdd_pkg, qdd_step.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_req_i) carries either a phase
//   sample (operation = OpSample) or a step read (operation = OpRead).
//   Output channel (out_valid_o / out_stall_i / out_rsp_o) returns exactly one
//   result per request: step_taken (+1/-1/0, 0 for samples) and the pending
//   step count after that request, in request order.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (reverse, edges per detent, min edge gap, pause reset); write only when idle.
//   Path: request register, then result register, from acceptance to the output port.
//   Throughput: one request per cycle unless the output stalls; the decode, debounce
//   and count update are a single table lookup, one 32-bit subtract and compares per cycle.
//   A stalled result holds in the output register while one more request is
//   taken into the input register; in_stall_o rises only when both are full.
//   Reset (rst_ni low, async) clears the baseline, the counts and both
//   pipeline valids, and loads configuration defaults.
`timescale 1ns / 1ps

module quadrature_detent_decoder_core import qdd_pkg::*; #(
  parameter int unsigned STEP_COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_req_t             in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_rsp_t            out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t                              cfg_q;
  logic                              s1_valid_q;
  in_req_t                           s1_req_q;
  dec_state_t                        state_q, state_d;
  logic signed [STEP_COUNT_BITS-1:0] count_q, count_d;
  logic                              out_valid_q;
  out_rsp_t                          out_rsp_q, rsp_d;
  logic                              advance;
  logic                              accept;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reverse_direction <= 1'b0;
      cfg_q.edges_per_detent  <= DetentW'(4);
      cfg_q.min_edge_gap_us   <= '0;
      cfg_q.pause_reset_us    <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgReverseDirection: cfg_q.reverse_direction <= cfg_wdata_i[0];
        CfgEdgesPerDetent:   cfg_q.edges_per_detent  <= cfg_wdata_i[DetentW-1:0];
        CfgMinEdgeGapUs:     cfg_q.min_edge_gap_us   <= cfg_wdata_i[TimeW-1:0];
        CfgPauseResetUs:     cfg_q.pause_reset_us    <= cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  qdd_step #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS)
  ) u_step (
    .cfg_i   (cfg_q),
    .req_i   (s1_req_q),
    .state_i (state_q),
    .count_i (count_q),
    .state_o (state_d),
    .count_o (count_d),
    .rsp_o   (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      count_q     <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        count_q     <= count_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_req_q <= in_req_i;
    if (advance) out_rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== rtl/qdd_checker.sv =====
// Port-level checks for the quadrature detent decoder, bound to the top level.
// Depends on qdd_pkg and quadrature_detent_decoder_core_macros.svh.
`timescale 1ns / 1ps
`include "quadrature_detent_decoder_core_macros.svh"

module qdd_checker import qdd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_i,
  input logic     out_valid_i,
  input logic     out_stall_i,
  input out_rsp_t out_rsp_i
);

  // a held result stays put until taken
  `QDD_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_rsp_i))

  // input backs up only when a full output is stalled
  `QDD_ASSERT(a_stall_cause, clk_i, rst_ni,
    in_stall_i |-> out_valid_i && out_stall_i)

  // a fresh result follows an accepted request that went through the input register
  `QDD_ASSERT(a_result_latency, clk_i, rst_ni,
    $rose(out_valid_i) |-> $past(in_valid_i && !in_stall_i, 2))

  // step_taken is only ever -1, 0 or +1
  `QDD_ASSERT_NEVER(a_step_range, clk_i, rst_ni,
    out_valid_i && out_rsp_i.step_taken == -2'sd2)

endmodule

bind quadrature_detent_decoder_core qdd_checker u_qdd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_i   (out_rsp_o)
);

// ===== bench/qdd_step_checker.sv =====
// Checker for the quadrature detent decoder: follows the request, result and
// register-write ports, predicts each result and compares it. Depends on qdd_pkg.
`timescale 1ns / 1ps

module qdd_step_checker import qdd_pkg::*; #(
  parameter int unsigned StepBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_req_t             in_req_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_rsp_t            out_rsp_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         awaited_o
);

  localparam longint CountMax = (longint'(1) <<< (StepBits - 1)) - 1;
  localparam longint CountMin = -CountMax - 1;

  // register copies
  logic               reverse_q;
  logic [DetentW-1:0] detent_cfg;
  logic [TimeW-1:0]   min_gap_cfg;
  logic [TimeW-1:0]   pause_cfg;

  // decoder state
  logic               primed;
  logic [1:0]         last_phase;
  logic [TimeW-1:0]   last_edge_us;
  int                 edge_sum;
  longint             step_cnt;

  out_rsp_t expected_rsp_q[$];

  // Next phase when turning in the counting direction: 00 -> 10 -> 11 -> 01 -> 00.
  function automatic logic [1:0] phase_ahead(input logic [1:0] p);
    case (p)
      2'b00:   return 2'b10;
      2'b10:   return 2'b11;
      2'b11:   return 2'b01;
      default: return 2'b00;
    endcase
  endfunction

  function automatic void track_sample(input logic [1:0] phase, input logic [TimeW-1:0] now);
    logic [TimeW-1:0] gap;
    int               dir;
    int               detent;
    gap = now - last_edge_us;
    if (!primed) begin
      primed       = 1'b1;
      last_phase   = phase;
      last_edge_us = now;
      return;
    end
    if (phase == last_phase) return;
    // debounced edge: phase follows, time and counts stay
    if (gap < min_gap_cfg) begin
      last_phase = phase;
      return;
    end
    if (gap > pause_cfg) edge_sum = 0;
    if (phase == phase_ahead(last_phase)) dir = 1;
    else if (last_phase == phase_ahead(phase)) dir = -1;
    else dir = 0;
    last_phase   = phase;
    last_edge_us = now;
    if (dir == 0) return;
    if (reverse_q) dir = -dir;
    detent = (int'(detent_cfg) < 2) ? 2 : int'(detent_cfg);
    edge_sum += dir;
    if (edge_sum >= detent) begin
      edge_sum = 0;
      if (step_cnt < CountMax) step_cnt++;
    end else if (edge_sum <= -detent) begin
      edge_sum = 0;
      if (step_cnt > CountMin) step_cnt--;
    end
  endfunction

  function automatic out_rsp_t predict_detent_rsp(input in_req_t req);
    out_rsp_t rsp;
    rsp.step_taken = 2'sd0;
    if (req.operation == OpSample) begin
      track_sample({req.phase_a, req.phase_b}, req.time_us);
    end else if (step_cnt > 0) begin
      step_cnt--;
      rsp.step_taken = 2'sd1;
    end else if (step_cnt < 0) begin
      step_cnt++;
      rsp.step_taken = -2'sd1;
    end
    rsp.pending_steps = PendW'(step_cnt);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t want;
    if (!rst_ni) begin
      reverse_q    = 1'b0;
      detent_cfg   = DetentW'(4);
      min_gap_cfg  = '0;
      pause_cfg    = '1;
      primed       = 1'b0;
      last_phase   = 2'b00;
      last_edge_us = '0;
      edge_sum     = 0;
      step_cnt     = 0;
      expected_rsp_q.delete();
      mismatch_count_o <= 0;
      awaited_o        <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgReverseDirection: reverse_q   = cfg_wdata_i[0];
          CfgEdgesPerDetent:   detent_cfg  = cfg_wdata_i[DetentW-1:0];
          CfgMinEdgeGapUs:     min_gap_cfg = cfg_wdata_i;
          CfgPauseResetUs:     pause_cfg   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: result with no request pending: step_taken %0d pending_steps %0d",
                   $time, out_rsp_i.step_taken, out_rsp_i.pending_steps);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = expected_rsp_q.pop_front();
          if (want !== out_rsp_i) begin
            if (want.step_taken !== out_rsp_i.step_taken)
              $display("%0t: step_taken expected %0d actual %0d",
                       $time, want.step_taken, out_rsp_i.step_taken);
            if (want.pending_steps !== out_rsp_i.pending_steps)
              $display("%0t: pending_steps expected %0d actual %0d",
                       $time, want.pending_steps, out_rsp_i.pending_steps);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_rsp_q.push_back(predict_detent_rsp(in_req_i));
      awaited_o <= expected_rsp_q.size();
    end
  end

endmodule

// ===== bench/tb_quadrature_detent_decoder_core.sv =====
// Testbench top for quadrature_detent_decoder_core: clock, reset, request and
// register stimulus, receiver stalls and verdict. Depends on qdd_pkg, qdd_step_checker.
`timescale 1ns / 1ps

module tb_quadrature_detent_decoder_core;
  import qdd_pkg::*;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_req_t             in_req    = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_rsp_t            out_rsp;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  int unsigned         mismatches;
  int unsigned         awaited;

  // stimulus state
  logic [1:0]       enc_phase = 2'b00;
  logic [TimeW-1:0] enc_now   = '0;
  logic [TimeW-1:0] cur_min_gap;
  logic [TimeW-1:0] cur_pause;
  bit               tx_bursty = 1'b1;
  bit               rx_quiet  = 1'b0;
  int               burst_left = 0;
  int               n_sent = 0;
  int               n_settings = 0;

  quadrature_detent_decoder_core #(.STEP_COUNT_BITS(16)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  qdd_step_checker #(.StepBits(16)) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_rsp_i        (out_rsp),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .awaited_o        (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("** quadrature_detent_decoder_core: FAILED **");
    $finish;
  end

  // receiver stalls: each stretch picks none, light, heavy or periodic
  initial begin : rx_stall_gen
    int mode;
    int left;
    int tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      left = $urandom_range(20, 200);
      repeat (left) begin
        @(posedge clk);
        tick++;
        if (rx_quiet || mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else if (mode == 2) out_stall <= ($urandom_range(0, 3) != 0);
        else out_stall <= ((tick % 5) < 2);
      end
    end
  end

  function automatic logic [1:0] turn(input logic [1:0] p, input bit cw);
    case (p)
      2'b00:   return cw ? 2'b10 : 2'b01;
      2'b10:   return cw ? 2'b11 : 2'b00;
      2'b11:   return cw ? 2'b01 : 2'b10;
      default: return cw ? 2'b00 : 2'b11;
    endcase
  endfunction

  // Called just after the clock rises; returns once the request has been taken.
  task automatic send_req(input in_req_t r);
    int gap;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic sample_to(input logic [1:0] ph, input logic [TimeW-1:0] inc);
    in_req_t r;
    enc_phase = ph;
    enc_now = enc_now + inc;
    r.operation = OpSample;
    r.phase_a = ph[1];
    r.phase_b = ph[0];
    r.time_us = enc_now;
    send_req(r);
  endtask

  task automatic read_step();
    in_req_t r;
    r.operation = OpRead;
    r.phase_a = $urandom_range(0, 1);
    r.phase_b = $urandom_range(0, 1);
    r.time_us = $urandom;
    send_req(r);
  endtask

  // hold off new requests until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (awaited != 0);
  endtask

  task automatic cfg_put(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // only while idle; unused upper data bits carry noise
  task automatic set_decoder(input bit rev, input logic [DetentW-1:0] det,
                             input logic [TimeW-1:0] min_gap, input logic [TimeW-1:0] pause);
    logic [CfgDataW-1:0] data;
    data = $urandom;
    data[0] = rev;
    cfg_put(CfgReverseDirection, data);
    data = $urandom;
    data[DetentW-1:0] = det;
    cfg_put(CfgEdgesPerDetent, data);
    cfg_put(CfgMinEdgeGapUs, min_gap);
    cfg_put(CfgPauseResetUs, pause);
    cfg_we <= 1'b0;
    cur_min_gap = min_gap;
    cur_pause = pause;
    n_settings++;
  endtask

  initial begin : stimulus
    in_req_t          r;
    int               pick;
    bit               cw;
    bit               rev;
    logic [DetentW-1:0] det;
    logic [TimeW-1:0] min_gap;
    logic [TimeW-1:0] pause;
    logic [TimeW-1:0] step_us;

    cur_min_gap = '0;
    cur_pause = '1;
    cw = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: read with nothing sampled, baseline, then edges across the time wrap
    read_step();
    enc_now = 32'hFFFF_FFF0;
    sample_to(2'b11, '0);
    sample_to(2'b11, 32'd5);
    sample_to(2'b00, 32'd3);               // both channels flip: no count
    repeat (4) sample_to(turn(enc_phase, 1'b1), 32'd7);
    repeat (3) sample_to(turn(enc_phase, 1'b0), 32'd7);
    read_step();
    read_step();
    sample_to(2'b10, 32'd1);
    sample_to(2'b01, 32'd1);

    // reversed, detent below minimum, debounce and pause clear
    drain();
    set_decoder(1'b1, DetentW'(0), 32'd50, 32'd200);
    sample_to(turn(enc_phase, 1'b1), 32'd10);
    sample_to(turn(enc_phase, 1'b1), 32'd60);
    sample_to(turn(enc_phase, 1'b1), 32'd300);
    sample_to(turn(enc_phase, 1'b1), 32'd60);
    read_step();
    read_step();

    // random walks with noise, one setting per round
    for (int round = 0; round < 6; round++) begin
      drain();
      case (round)
        0: begin
          rev = 1'b0; det = DetentW'(2); min_gap = '0; pause = '1;
        end
        1: begin
          rev = 1'b1; det = DetentW'(64); min_gap = '0; pause = '0;
        end
        2: begin
          rev = 1'b1; det = DetentW'(127); min_gap = 32'd1; pause = '1;
        end
        3: begin
          rev = 1'b0; det = DetentW'(3); min_gap = '1; pause = 32'd100;
        end
        default: begin
          rev = $urandom_range(0, 1);
          det = ($urandom_range(0, 3) == 0) ? DetentW'($urandom_range(0, 127))
                                            : DetentW'($urandom_range(0, 6));
          min_gap = $urandom_range(0, 150);
          pause = $urandom_range(100, 2000);
        end
      endcase
      set_decoder(rev, det, min_gap, pause);
      tx_bursty = (round != 2);
      rx_quiet = (round == 4);
      repeat (310) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0:       step_us = cur_min_gap - 1;
          1:       step_us = cur_min_gap;
          2:       step_us = cur_pause;
          3:       step_us = cur_pause + 1;
          4:       step_us = $urandom;
          default: step_us = $urandom_range(0, 400);
        endcase
        if (pick < 65) begin
          if ($urandom_range(0, 7) == 0) cw = ~cw;
          sample_to(turn(enc_phase, cw), step_us);
        end else if (pick < 80) begin
          read_step();
        end else if (pick < 87) begin
          sample_to(enc_phase, step_us);
        end else if (pick < 93) begin
          sample_to(~enc_phase, step_us);
        end else begin
          r.operation = qdd_op_e'($urandom_range(0, 1));
          r.phase_a = $urandom_range(0, 1);
          r.phase_b = $urandom_range(0, 1);
          r.time_us = $urandom;
          if (r.operation == OpSample) begin
            enc_phase = {r.phase_a, r.phase_b};
            enc_now = r.time_us;
          end
          send_req(r);
        end
      end
    end

    // back-to-back edges with the smallest detent, swinging the count both ways
    drain();
    set_decoder(1'b0, DetentW'(1), '0, '1);
    tx_bursty = 1'b0;
    rx_quiet = 1'b1;
    repeat (40) sample_to(turn(enc_phase, 1'b1), 32'd1);
    read_step();
    repeat (40) sample_to(turn(enc_phase, 1'b0), 32'd1);
    read_step();
    read_step();

    drain();
    rx_quiet = 1'b0;
    repeat (10) @(posedge clk);
    $display("Ran %0d requests under %0d decoder settings: debounce, pause clear,", n_sent,
             n_settings);
    $display("invalid and repeated phases, time wrap, reads and counts of both signs.");
    if (mismatches == 0 && awaited == 0) begin
      $display("** quadrature_detent_decoder_core: PASSED **");
    end else begin
      $display("** quadrature_detent_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
